FILE: src/hhd_pkg.sv
// Shared types, constants and the half-sine series for the H-bridge haptic drive.
// No dependencies; every other file in src imports this package.
package hhd_pkg;

    // Defaults and fixed constants
    localparam int TABLE_SIZE_DEF = 256;
    localparam int SPEED_FULL     = 2000;
    localparam int DEADBAND       = 66;
    localparam int DIV_STEPS      = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMPACT_REF = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_MIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_MAX  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_ROLL   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROLL_GAIN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_FS    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_SCALE,
        ST_END,
        ST_SUM,
        ST_CMP,
        ST_LOAD
    } state_t;

    // Status and results of one serial divider
    typedef struct packed {
        logic        busy;
        logic        ovf;
        logic [15:0] quot;
        logic [15:0] rem;
    } sdiv_out_t;

    // Q0.16 sine of a Q30 angle in [0, pi/2]; five Taylor terms past the first.
    function automatic logic [15:0] hs_from_theta(input logic [63:0] theta);
        logic [63:0] term;
        logic signed [65:0] sum;
        logic [63:0] v;
        term = theta;
        sum  = $signed({2'b00, theta});
        term = ((term * theta) >> 30);
        term = ((term * theta) >> 30) / 64'd6;
        sum  = sum - $signed({2'b00, term});
        term = ((term * theta) >> 30);
        term = ((term * theta) >> 30) / 64'd20;
        sum  = sum + $signed({2'b00, term});
        term = ((term * theta) >> 30);
        term = ((term * theta) >> 30) / 64'd42;
        sum  = sum - $signed({2'b00, term});
        term = ((term * theta) >> 30);
        term = ((term * theta) >> 30) / 64'd72;
        sum  = sum + $signed({2'b00, term});
        term = ((term * theta) >> 30);
        term = ((term * theta) >> 30) / 64'd110;
        sum  = sum - $signed({2'b00, term});
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({2'b00, ONE_Q30})) begin
            sum = $signed({2'b00, ONE_Q30});
        end
        v = ((64'(sum) * 64'd65535) + (64'd1 << 29)) >> 30;
        if (v > 64'd65535) begin
            v = 64'd65535;
        end
        return v[15:0];
    endfunction

endpackage

FILE: src/haptic_hbridge_drive_core.sv
// Top level of the H-bridge haptic drive: FSM, pulse state, duty datapath.
// Depends on hhd_pkg, hhd_sdiv and hhd_sine_rom.
//
// One physics tick in, one pair of PWM duties out. An input transfer carries the tick
// time, ball position and velocity (tdata) and the rolling flag (tuser). A nonzero impact
// speed loads a Q0.16 pulse amplitude, min(impact*65535/impact_ref_speed, 65535), and a
// pulse end time; while the tick time is before that end, duty_plus carries the pulse and
// duty_minus is zero. Otherwise the end is cleared and, if the ball rolls at or above
// min_roll_speed, duty_minus carries a half-sine rumble picked by |position| mod
// TABLE_SIZE and scaled by min(|v|,2000)*roll_gain/2000. Magnitudes below 66 give a zero
// duty. From input transfer to a loaded result each tick passes a start state, then a
// divide state in which three restoring serial dividers (impact amplitude, rolling
// gain, table index) run side by side and produce one quotient bit per cycle until all
// are idle, then five short stages (scale, products, end-time sum, compare, load). The
// block takes one tick at a time; s_tready returns once the result sits in the output
// register, so the next tick can start while m_tvalid waits.
// Configuration writes are accepted on any cycle but belong in idle time.
module haptic_hbridge_drive_core #(
    parameter int TABLE_SIZE = hhd_pkg::TABLE_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input ticks
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] now_ms, [47:32] position_mm, [63:48] velocity_mmps, [79:64] impact_mmps
    input  logic [79:0]                    s_tdata,
    // [0] is_rolling
    input  logic                           s_tuser,
    // result duties
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] duty_plus, [31:16] duty_minus
    output logic [31:0]                    m_tdata,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [hhd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]                    cfg_wdata
);
    import hhd_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // configuration registers
    logic [15:0] impact_ref_reg;
    logic [9:0]  pulse_min_reg;
    logic [9:0]  pulse_max_reg;
    logic [15:0] min_roll_reg;
    logic [15:0] roll_gain_reg;
    logic [15:0] duty_fs_reg;

    // persistent pulse state
    logic [31:0] pulse_end_reg;
    logic [15:0] pulse_amp_reg;

    // control
    state_t      state_reg, state_next;
    logic        m_valid_reg;
    logic        accept, div_start, out_load;

    // captured tick
    logic [31:0] now_reg;
    logic [15:0] speed_reg;
    logic [15:0] apos_reg;
    logic [15:0] impact_reg;
    logic        rolling_reg;

    // intermediate results
    logic [15:0] amp_reg;
    logic [15:0] g_reg;
    logic        roll_ok_reg;
    logic [25:0] span_prod_reg;
    logic [15:0] mag_reg;
    logic [31:0] end_cand_reg;
    logic        active_reg;
    logic [31:0] m_data_reg;

    // combinational helpers
    logic [15:0] vel_in, pos_in, vel_abs, pos_abs;
    logic [10:0] speed_clip;
    logic [26:0] g_dividend;
    logic [31:0] imp_dividend;
    logic [9:0]  span;
    logic [10:0] dur;
    logic        active;
    logic [15:0] sel_mag;
    logic [31:0] duty_prod;
    logic [15:0] duty;
    logic [31:0] mag_prod;
    logic [15:0] rom_data;

    sdiv_out_t   imp_div, g_div, mod_div;

    // ---------------------------------------------------------------- config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            impact_ref_reg <= 16'd3000;
            pulse_min_reg  <= 10'd10;
            pulse_max_reg  <= 10'd40;
            min_roll_reg   <= 16'd20;
            roll_gain_reg  <= 16'd52428;
            duty_fs_reg    <= 16'd1023;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IMPACT_REF: impact_ref_reg <= cfg_wdata;
                CFG_PULSE_MIN:  pulse_min_reg  <= cfg_wdata[9:0];
                CFG_PULSE_MAX:  pulse_max_reg  <= cfg_wdata[9:0];
                CFG_MIN_ROLL:   min_roll_reg   <= cfg_wdata;
                CFG_ROLL_GAIN:  roll_gain_reg  <= cfg_wdata;
                CFG_DUTY_FS:    duty_fs_reg    <= cfg_wdata;
                default:        ; // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) begin
                          state_next = ST_START;
                      end
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (!imp_div.busy) begin
                          state_next = ST_SCALE;
                      end
            ST_SCALE: state_next = ST_END;
            ST_END:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_LOAD;
            ST_LOAD:  if (!m_valid_reg || m_tready) begin
                          state_next = ST_IDLE;
                      end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_START);
        // hold the finished duties until the output register frees up
        out_load  = (state_reg == ST_LOAD) && (!m_valid_reg || m_tready);
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- capture
    assign pos_in  = s_tdata[47:32];
    assign vel_in  = s_tdata[63:48];
    // magnitude of a 16-bit two's complement value; -32768 maps to 32768
    assign vel_abs = vel_in[15] ? 16'(~vel_in + 16'd1) : vel_in;
    assign pos_abs = pos_in[15] ? 16'(~pos_in + 16'd1) : pos_in;

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg     <= s_tdata[31:0];
            apos_reg    <= pos_abs;
            speed_reg   <= vel_abs;
            impact_reg  <= s_tdata[79:64];
            rolling_reg <= s_tuser;
        end
    end

    // ---------------------------------------------------------------- dividers
    assign imp_dividend = {impact_reg, 16'd0} - {16'd0, impact_reg};  // impact*65535
    assign speed_clip   = (speed_reg > 16'(SPEED_FULL)) ? 11'(SPEED_FULL) : speed_reg[10:0];
    assign g_dividend   = speed_clip * roll_gain_reg;

    // a zero reference speed yields an all-ones quotient, which saturates
    hhd_sdiv u_div_imp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (imp_dividend),
        .divisor  (impact_ref_reg),
        .res      (imp_div)
    );

    hhd_sdiv u_div_gain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({5'd0, g_dividend}),
        .divisor  (16'(SPEED_FULL)),
        .res      (g_div)
    );

    // remainder gives |position| mod TABLE_SIZE
    hhd_sdiv u_div_idx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({16'd0, apos_reg}),
        .divisor  (16'(TABLE_SIZE)),
        .res      (mod_div)
    );

    hhd_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .aclk (aclk),
        .addr (mod_div.rem[IDX_W-1:0]),
        .data (rom_data)
    );

    // ---------------------------------------------------------------- datapath
    assign span      = (pulse_max_reg > pulse_min_reg) ? pulse_max_reg - pulse_min_reg : 10'd0;
    assign dur       = {1'b0, pulse_min_reg} + {1'b0, span_prod_reg[25:16]};
    assign mag_prod  = rom_data * g_reg;
    assign active    = (end_cand_reg != 32'd0) && (now_reg < end_cand_reg);
    assign sel_mag   = active_reg ? pulse_amp_reg : (roll_ok_reg ? mag_reg : 16'd0);
    assign duty_prod = sel_mag * duty_fs_reg;
    assign duty      = (sel_mag < 16'(DEADBAND)) ? 16'd0 : duty_prod[31:16];

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_SCALE: begin
                amp_reg     <= imp_div.ovf ? 16'hFFFF : imp_div.quot;
                g_reg       <= g_div.quot;
                roll_ok_reg <= rolling_reg && (speed_reg >= min_roll_reg);
            end
            ST_END: begin
                span_prod_reg <= span * amp_reg;
                mag_reg       <= mag_prod[31:16];
            end
            ST_SUM: begin
                // end time wraps mod 2^32
                end_cand_reg <= (impact_reg != 16'd0) ? now_reg + 32'(dur) : pulse_end_reg;
            end
            ST_CMP: begin
                active_reg <= active;
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg <= active_reg ? {16'd0, duty} : {duty, 16'd0};
        end
    end

    // pulse state: amplitude stored on any impact, end cleared once it has passed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_end_reg <= 32'd0;
            pulse_amp_reg <= 16'd0;
        end else begin
            if (state_reg == ST_END && impact_reg != 16'd0) begin
                pulse_amp_reg <= amp_reg;
            end
            if (state_reg == ST_CMP) begin
                pulse_end_reg <= active ? end_cand_reg : 32'd0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // the three dividers start together and must finish together
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (imp_div.busy == g_div.busy) && (imp_div.busy == mod_div.busy))
        else $error("serial dividers out of lockstep");

    // a stored pulse end always lies after the current tick time
    a_end_future: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> ((pulse_end_reg == 32'd0) || (now_reg < pulse_end_reg)))
        else $error("pulse end kept although already passed");

    // plus and minus pins never drive at once
    a_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[15:0] != 16'd0)) |-> (m_tdata[31:16] == 16'd0))
        else $error("both bridge duties nonzero");

    // a result appears only from the load state
    a_load_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LOAD))
        else $error("result valid without load");
`endif

endmodule

FILE: src/hhd_sdiv.sv
// Restoring serial divider: one quotient bit per cycle, 32-bit dividend, 16-bit divisor.
// Uses hhd_pkg for the step count and the result struct.
module hhd_sdiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [15:0]       divisor,
    output hhd_pkg::sdiv_out_t res
);
    import hhd_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          dvd_reg, dvd_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          quot_reg, quot_next;
    logic                 ovf_reg, ovf_next;
    logic [16:0]          trial, diff;
    logic                 fits, busy;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, dvd_reg[31]};
    assign fits  = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            dvd_next  = dividend;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end else if (busy) begin
            cnt_next  = cnt_reg - 1'b1;
            dvd_next  = {dvd_reg[30:0], 1'b0};
            rem_next  = fits ? diff[15:0] : trial[15:0];
            quot_next = {quot_reg[14:0], fits};
            // quotient bits shifted out above bit 15 mean saturation
            ovf_next  = ovf_reg | quot_reg[15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign res.busy = busy;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

FILE: src/hhd_sine_rom.sv
// Half-sine lookup table built at elaboration, with registered read.
// Uses hhd_pkg for the series function and the angle constant.
module hhd_sine_rom #(
    parameter int TABLE_SIZE = hhd_pkg::TABLE_SIZE_DEF,
    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic             aclk,
    input  logic [IDX_W-1:0] addr,
    output logic [15:0]      data
);
    import hhd_pkg::*;

    localparam logic [63:0] N1 = 64'(TABLE_SIZE - 1);

    logic [15:0] tab [TABLE_SIZE];
    logic [15:0] data_reg;

    for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_tab
        // fold onto the rising quarter so the table is symmetric
        localparam logic [63:0] T_FOLD = (N1 - 64'(i) < 64'(i)) ? N1 - 64'(i) : 64'(i);
        localparam logic [63:0] THETA  = (PI_Q30 * T_FOLD) / N1;
        assign tab[i] = hs_from_theta(THETA);
    end

    always_ff @(posedge aclk) begin
        data_reg <= tab[addr];
    end

    assign data = data_reg;

endmodule
